// ----- src/ddsp_pkg.sv -----
// Shared widths, register indexes and types for the dense shortest-path block.
package ddsp_pkg;

  localparam int EDGE_W     = 20;
  localparam int DIST_W     = 32;
  localparam int PRED_W     = 6;
  localparam int VCNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [DIST_W-1:0] dist_t;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'b1;

  localparam logic [VCNT_W-1:0] VCNT_RESET      = 7'd64;
  localparam dist_t             THRESHOLD_RESET = 32'd1000000;
  localparam dist_t             DIST_MAX        = 32'hFFFF_FFFF;

endpackage

// ----- src/ddsp_edge_if.sv -----
// Input channel carrying one adjacency matrix weight per transfer.
interface ddsp_edge_if;
  import ddsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_weight;

  modport source (output valid, output edge_weight, input ready);
  modport sink   (input valid, input edge_weight, output ready);
endinterface

// ----- src/ddsp_result_if.sv -----
// Output channel carrying one per-vertex shortest-path result per transfer.
interface ddsp_result_if;
  import ddsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [PRED_W-1:0] predecessor;
  logic              unreachable;
  logic              last_vertex;

  modport source (output valid, output distance, output predecessor,
                  output unreachable, output last_vertex, input ready);
  modport sink   (input valid, input distance, input predecessor,
                  input unreachable, input last_vertex, output ready);
endinterface

// ----- src/ddsp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ddsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dense_dijkstra_shortest_paths_top.sv -----
// Dense single-source shortest paths from vertex 0 over a loaded adjacency matrix.
//
// Usage: set vertex_count (index 0) and unreachable_threshold (index 1) through
// the write port while the block is idle; writing vertex_count restarts the
// matrix load. Then send the N x N weights on edge_i in row-major order, one
// transfer per cycle. After the last weight the input is held off while the
// block solves, and then sends N results on result_o in vertex order, the last
// one marked with last_vertex.
// Operation: the solve is one scan over the distance memory to initialise, then
// N-1 rounds; each round streams one matrix row and the distance memory through
// a three-stage read/relax/write pipeline and drains it before the next pick.
// Each result is read from the registered memories ahead of the output register,
// and the next one is read only once that register is free or being taken.
// Input is taken again once the last result sits in the output register.
// A stalled receiver simply holds the output register and pauses emission.
// Reset returns vertex_count to 64, the threshold to 1000000, clears the load
// position and empties the pipeline; the memories keep their contents.
module dense_dijkstra_shortest_paths_top #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ddsp_edge_if.sink                       edge_i,
  ddsp_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [ddsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ddsp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ddsp_pkg::*;

  localparam int VW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_WR = 3'd4;

  // Configuration and control state.
  logic [2:0]              state_q;
  logic [VCNT_W-1:0]       vcount_q;
  dist_t                   thresh_q;
  logic [VW-1:0]           n_m1;
  logic [VW-1:0]           ncur_q;
  logic [VW-1:0]           row_q, col_q;
  logic [AW-1:0]           load_base_q;
  logic [VW-1:0]           scan_q;
  logic [VW-1:0]           round_q;
  logic                    init_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [AW-1:0]           pick_base_q;
  logic [VW-1:0]           pick_q;
  dist_t                   best_q;
  logic                    found_q;
  dist_t                   nbest_q;
  logic [VW-1:0]           npick_q;

  // Relax pipeline.
  logic                    s1_vld_q, s2_vld_q;
  logic [VW-1:0]           s1_v_q, s2_v_q;
  logic                    s1_unvis_q, s2_unvis_q;
  dist_t                   s2_d_q;
  logic                    s2_we_q;
  dist_t                   s2_d_d;
  logic                    s2_we_d;

  // Output register.
  logic                    out_vld_q;
  dist_t                   out_dist_q;
  logic [PRED_W-1:0]       out_pred_q;
  logic                    out_unr_q;
  logic                    out_last_q;

  // Memory ports.
  logic                    in_xfer;
  logic [WEIGHT_BITS-1:0]  w_in;
  logic [WEIGHT_BITS-1:0]  w_rdata;
  dist_t                   d_rdata;
  logic [VW-1:0]           p_rdata;
  logic [VW-1:0]           p_wdata;
  logic [DIST_W:0]         sum;
  dist_t                   cand;
  logic                    pick_now;

  // Active vertex count minus one, with out-of-range counts clamped.
  always_comb begin
    if (vcount_q < VCNT_W'(2)) begin
      n_m1 = VW'(1);
    end else if (vcount_q > VCNT_W'(MAX_VERTICES)) begin
      n_m1 = VW'(MAX_VERTICES - 1);
    end else begin
      n_m1 = VW'(vcount_q - VCNT_W'(1));
    end
  end

  assign edge_i.ready = (state_q == S_LOAD);
  assign in_xfer      = edge_i.valid && edge_i.ready;
  assign w_in         = WEIGHT_BITS'(edge_i.edge_weight);
  assign p_wdata      = init_q ? '0 : pick_q;
  assign pick_now     = (state_q == S_DRAIN) && !s1_vld_q && !s2_vld_q;

  ddsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (load_base_q + AW'(col_q)),
    .wdata_i (w_in),
    .raddr_i (pick_base_q + AW'(scan_q)),
    .rdata_o (w_rdata)
  );

  ddsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q && s2_we_q),
    .waddr_i (s2_v_q),
    .wdata_i (s2_d_q),
    .raddr_i (scan_q),
    .rdata_o (d_rdata)
  );

  ddsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q && s2_we_q),
    .waddr_i (s2_v_q),
    .wdata_i (p_wdata),
    .raddr_i (scan_q),
    .rdata_o (p_rdata)
  );

  // Relax stage: saturating candidate through the current pick. The
  // initialising scan copies row 0 straight into the distances instead.
  assign sum  = {1'b0, best_q} + (DIST_W + 1)'(w_rdata);
  assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  always_comb begin
    if (init_q) begin
      s2_we_d = 1'b1;
      s2_d_d  = DIST_W'(w_rdata);
    end else begin
      s2_we_d = s1_unvis_q && (cand < d_rdata);
      s2_d_d  = s2_we_d ? cand : d_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      vcount_q    <= VCNT_RESET;
      thresh_q    <= THRESHOLD_RESET;
      ncur_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      load_base_q <= '0;
      scan_q      <= '0;
      round_q     <= '0;
      init_q      <= 1'b0;
      visited_q   <= '0;
      pick_base_q <= '0;
      pick_q      <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      nbest_q     <= '0;
      npick_q     <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= s1_vld_q;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VERTEX_COUNT: begin
            vcount_q    <= cfg_data_i[VCNT_W-1:0];
            row_q       <= '0;
            col_q       <= '0;
            load_base_q <= '0;
          end
          REG_THRESHOLD: begin
            thresh_q <= cfg_data_i[DIST_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // Running minimum over unvisited vertices picks the next round's vertex.
      if (s2_vld_q && s2_unvis_q && (!found_q || s2_d_q < nbest_q)) begin
        found_q <= 1'b1;
        nbest_q <= s2_d_q;
        npick_q <= s2_v_q;
      end

      if (result_o.valid && result_o.ready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_LOAD: begin
          if (in_xfer && !(cfg_we_i && cfg_idx_i == REG_VERTEX_COUNT)) begin
            if (col_q == n_m1) begin
              col_q <= '0;
              if (row_q == n_m1) begin
                row_q       <= '0;
                load_base_q <= '0;
                ncur_q      <= n_m1;
                state_q     <= S_SCAN;
                init_q      <= 1'b1;
                scan_q      <= '0;
                round_q     <= '0;
                pick_base_q <= '0;
                visited_q   <= MAX_VERTICES'(1);
                found_q     <= 1'b0;
              end else begin
                row_q       <= row_q + VW'(1);
                load_base_q <= load_base_q + AW'(MAX_VERTICES);
              end
            end else begin
              col_q <= col_q + VW'(1);
            end
          end
        end
        S_SCAN: begin
          s1_vld_q <= 1'b1;
          if (scan_q == ncur_q) begin
            state_q <= S_DRAIN;
          end else begin
            scan_q <= scan_q + VW'(1);
          end
        end
        S_DRAIN: begin
          if (pick_now) begin
            scan_q <= '0;
            if (round_q == ncur_q) begin
              state_q <= S_EMIT_RD;
            end else begin
              round_q            <= round_q + VW'(1);
              best_q             <= nbest_q;
              pick_q             <= npick_q;
              visited_q[npick_q] <= 1'b1;
              pick_base_q        <= AW'(npick_q) * AW'(MAX_VERTICES);
              found_q            <= 1'b0;
              init_q             <= 1'b0;
              state_q            <= S_SCAN;
            end
          end
        end
        S_EMIT_RD: begin
          if (!out_vld_q || result_o.ready) begin
            state_q <= S_EMIT_WR;
          end
        end
        S_EMIT_WR: begin
          out_vld_q <= 1'b1;
          if (scan_q == ncur_q) begin
            scan_q  <= '0;
            state_q <= S_LOAD;
          end else begin
            scan_q  <= scan_q + VW'(1);
            state_q <= S_EMIT_RD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s1_v_q     <= scan_q;
    s1_unvis_q <= !visited_q[scan_q];
    s2_v_q     <= s1_v_q;
    s2_unvis_q <= s1_unvis_q;
    s2_d_q     <= s2_d_d;
    s2_we_q    <= s2_we_d;
    if (state_q == S_EMIT_WR) begin
      out_dist_q <= d_rdata;
      out_pred_q <= PRED_W'(p_rdata);
      out_unr_q  <= (d_rdata >= thresh_q);
      out_last_q <= (scan_q == ncur_q);
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.distance    = out_dist_q;
  assign result_o.predecessor = out_pred_q;
  assign result_o.unreachable = out_unr_q;
  assign result_o.last_vertex = out_last_q;

  // The output register is always free when a read result arrives for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_WR) |-> !out_vld_q)
    else $error("result overwrote a waiting output transfer");

  // Each round must find an unvisited vertex to pick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pick_now && round_q != ncur_q) |-> (found_q && !visited_q[npick_q]))
    else $error("round picked no vertex or a visited one");

  // Distance writes only happen while the solve pipeline is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("pipeline write outside the solve phase");

  // The load position stays inside the active matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= n_m1) && (col_q <= n_m1))
    else $error("load position outside the matrix");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the dense shortest-path block, with its own path predictor.
module tb_top;
  import ddsp_pkg::*;

  localparam int MAX_V          = 64;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_WEIGHTS = 40;
  localparam int REPORT_LIMIT   = 40;

  typedef logic [EDGE_W-1:0] weight_t;
  typedef weight_t weight_list_t[$];

  typedef struct {
    dist_t             distance;
    logic [PRED_W-1:0] predecessor;
    logic              unreachable;
    logic              last_vertex;
  } path_result_t;

  localparam weight_t NO_EDGE = '1;

  typedef enum int unsigned {
    GRAPH_TIGHT,
    GRAPH_SPARSE,
    GRAPH_WIDE,
    GRAPH_EXTREMES
  } graph_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ddsp_edge_if   edge_bus ();
  ddsp_result_if result_bus ();

  dense_dijkstra_shortest_paths_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_i     (edge_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the matrix, the registers and the load position.
  weight_t           adjacency [MAX_V][MAX_V];
  logic [VCNT_W-1:0] vertex_count_q = VCNT_RESET;
  dist_t             threshold_q    = THRESHOLD_RESET;
  int unsigned       load_pos       = 0;
  path_result_t      expected_paths[$];

  int mismatches    = 0;
  int paths_checked = 0;
  int weights_sent  = 0;
  int graphs_solved = 0;
  int hold_asks     = 0;
  int holds_taken   = 0;
  bit calm          = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned active_vertices();
    if (vertex_count_q < 2) return 2;
    if (vertex_count_q > MAX_V) return MAX_V;
    return vertex_count_q;
  endfunction

  function automatic dist_t add_saturating(dist_t a, weight_t b);
    logic [DIST_W:0] sum;
    sum = {1'b0, a} + {{(DIST_W + 1 - EDGE_W){1'b0}}, b};
    return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  endfunction

  function automatic void solve_paths(int unsigned n);
    dist_t             path_dist [MAX_V];
    logic [PRED_W-1:0] pred [MAX_V];
    bit                seen [MAX_V];
    dist_t             best;
    dist_t             cand;
    int unsigned       pick;
    bit                found;
    path_result_t      res;
    for (int unsigned v = 0; v < n; v++) begin
      path_dist[v] = {{(DIST_W - EDGE_W){1'b0}}, adjacency[0][v]};
      pred[v] = '0;
      seen[v] = 1'b0;
    end
    seen[0] = 1'b1;
    for (int unsigned round = 1; round < n; round++) begin
      found = 1'b0;
      best  = '0;
      pick  = 0;
      // Strict comparison keeps the lowest index on ties.
      for (int unsigned v = 0; v < n; v++) begin
        if (!seen[v] && (!found || path_dist[v] < best)) begin
          best  = path_dist[v];
          pick  = v;
          found = 1'b1;
        end
      end
      if (!found) break;
      seen[pick] = 1'b1;
      for (int unsigned v = 0; v < n; v++) begin
        if (!seen[v]) begin
          cand = add_saturating(best, adjacency[pick][v]);
          if (cand < path_dist[v]) begin
            path_dist[v] = cand;
            pred[v] = pick[PRED_W-1:0];
          end
        end
      end
    end
    for (int unsigned v = 0; v < n; v++) begin
      res.distance    = path_dist[v];
      res.predecessor = pred[v];
      res.unreachable = (path_dist[v] >= threshold_q);
      res.last_vertex = (v == n - 1);
      expected_paths.push_back(res);
    end
    graphs_solved++;
  endfunction

  function automatic void take_weight(weight_t w);
    int unsigned n;
    int unsigned total;
    n     = active_vertices();
    total = n * n;
    if (load_pos >= total) load_pos = 0;
    adjacency[load_pos / n][load_pos % n] = w;
    load_pos++;
    if (load_pos == total) begin
      load_pos = 0;
      solve_paths(n);
    end
  endfunction

  function automatic weight_list_t random_matrix(int unsigned n, graph_style_e style);
    weight_list_t ws;
    repeat (n * n) begin
      case (style)
        GRAPH_TIGHT: begin
          ws.push_back(weight_t'($urandom_range(0, 15)));
        end
        GRAPH_SPARSE: begin
          if ($urandom_range(0, 99) < 65) ws.push_back(NO_EDGE);
          else ws.push_back(weight_t'($urandom_range(1, 2000)));
        end
        GRAPH_WIDE: begin
          ws.push_back(weight_t'($urandom));
        end
        default: begin
          case ($urandom_range(0, 2))
            0: ws.push_back('0);
            1: ws.push_back(NO_EDGE);
            default: ws.push_back(weight_t'($urandom));
          endcase
        end
      endcase
    end
    return ws;
  endfunction

  function automatic dist_t random_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return DIST_MAX;
      2: return dist_t'(NO_EDGE);
      3: return dist_t'($urandom_range(0, 4000));
      default: return dist_t'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    path_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_paths.size() == 0) begin
        note_mismatch($sformatf("result with none expected, distance %0d",
                                result_bus.distance));
      end else begin
        want = expected_paths.pop_front();
        if (result_bus.distance !== want.distance)
          note_mismatch($sformatf("result %0d distance %0d, expected %0d",
                                  paths_checked, result_bus.distance, want.distance));
        if (result_bus.predecessor !== want.predecessor)
          note_mismatch($sformatf("result %0d predecessor %0d, expected %0d",
                                  paths_checked, result_bus.predecessor, want.predecessor));
        if (result_bus.unreachable !== want.unreachable)
          note_mismatch($sformatf("result %0d unreachable %b, expected %b",
                                  paths_checked, result_bus.unreachable, want.unreachable));
        if (result_bus.last_vertex !== want.last_vertex)
          note_mismatch($sformatf("result %0d last_vertex %b, expected %b",
                                  paths_checked, result_bus.last_vertex, want.last_vertex));
      end
      paths_checked++;
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever a test asks for one.
  initial begin
    int hold_left;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_taken) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Leaves valid high on return, so the caller either sends again at once or goes idle.
  task automatic send_weight(input weight_t w);
    if (!calm) begin
      while ($urandom_range(0, 99) < 6) begin
        edge_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    edge_bus.valid       <= 1'b1;
    edge_bus.edge_weight <= w;
    @(posedge clk_i);
    while (!edge_bus.ready) @(posedge clk_i);
    weights_sent++;
    take_weight(w);
  endtask

  task automatic send_weights(input weight_list_t ws);
    foreach (ws[i]) send_weight(ws[i]);
  endtask

  task automatic wait_idle();
    edge_bus.valid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_VERTEX_COUNT) begin
      vertex_count_q = data[VCNT_W-1:0];
      load_pos       = 0;
    end else begin
      threshold_q = data;
    end
    @(posedge clk_i);
  endtask

  // Upper data bits are random: only the low bits of the count register matter.
  task automatic write_count(input logic [VCNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] data;
    data             = $urandom;
    data[VCNT_W-1:0] = count;
    write_reg(REG_VERTEX_COUNT, data);
  endtask

  task automatic test_reset_values();
    weight_list_t ws;
    // At the reset count a short run of weights is only a partial load and yields nothing.
    repeat (20) send_weight(weight_t'($urandom));
    wait_idle();
    // Only the count is written, so the reset threshold still applies on both sides of it.
    write_count(7'd3);
    ws = '{20'd0, NO_EDGE, 20'd999999,
           20'd4, 20'd0,   20'd1,
           NO_EDGE, 20'd2, 20'd0};
    send_weights(ws);
    wait_idle();
  endtask

  task automatic test_tie_break_and_relax();
    weight_list_t ws;
    // Vertices 1 and 2 tie on the first pick; vertex 3 improves twice.
    ws = '{20'h55555, 20'd3, 20'd3, NO_EDGE,
           20'd9,     20'd0, 20'd0, 20'd1,
           20'd0,     20'd0, 20'd0, 20'd0,
           20'hAAAAA, NO_EDGE, 20'd0, 20'h12345};
    write_count(7'd4);
    write_reg(REG_THRESHOLD, 32'd5);
    send_weights(ws);
    wait_idle();
  endtask

  task automatic test_threshold_mid_load();
    weight_list_t ws;
    ws = '{20'd7, NO_EDGE, 20'd2};
    // A count below the range behaves as two vertices.
    write_count(7'd1);
    send_weights(ws);
    wait_idle();
    // The threshold write must not disturb the partial load.
    write_reg(REG_THRESHOLD, '0);
    send_weight('0);
    wait_idle();
  endtask

  task automatic test_count_write_restarts_load();
    weight_list_t ws;
    write_reg(REG_THRESHOLD, CFG_DATA_W'(NO_EDGE));
    write_count(7'd2);
    ws = '{20'd1, 20'd1};
    send_weights(ws);
    wait_idle();
    write_count(7'd0);
    ws = '{20'd0, NO_EDGE, 20'd0, 20'd0};
    send_weights(ws);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_count(7'd6);
    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 3000)));
    // The receiver stops while whole graphs keep coming, so the block backs up to its input.
    hold_asks++;
    repeat (2) send_weights(random_matrix(6, graph_style_e'($urandom_range(0, 3))));
    wait_idle();
  endtask

  task automatic test_random_graphs();
    int unsigned first;
    int unsigned round;
    int unsigned part;
    first = weights_sent;
    round = 0;
    while (weights_sent - first < RANDOM_WEIGHTS) begin
      calm = (round == 0);
      if ($urandom_range(0, 1) == 1) write_reg(REG_THRESHOLD, random_threshold());
      if ($urandom_range(0, 4) == 0) begin
        // An abandoned partial load, then a count write that restarts it.
        part = $urandom_range(1, active_vertices() * active_vertices() - 1);
        repeat (part) send_weight(weight_t'($urandom));
        wait_idle();
        write_count(VCNT_W'($urandom_range(0, 7)));
      end else if ($urandom_range(0, 2) != 0) begin
        write_count(VCNT_W'($urandom_range(0, 7)));
      end
      repeat ($urandom_range(1, 3))
        send_weights(random_matrix(active_vertices(), graph_style_e'($urandom_range(0, 3))));
      wait_idle();
      round++;
    end
    calm = 1'b0;
  endtask

  task automatic test_largest_graph();
    write_reg(REG_THRESHOLD, DIST_MAX);
    // A count above the range behaves as the largest graph, so this run stays partial.
    write_count(7'd127);
    repeat (40) send_weight(weight_t'($urandom));
    wait_idle();
    // The restarted load then completes a small graph.
    write_count(7'd2);
    send_weights(random_matrix(2, GRAPH_TIGHT));
    wait_idle();
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_VERTEX_COUNT;
    cfg_data_i           <= '0;
    edge_bus.valid       <= 1'b0;
    edge_bus.edge_weight <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_tie_break_and_relax();
    test_threshold_mid_load();
    test_count_write_restarts_load();
    test_backpressure();
    test_random_graphs();
    test_largest_graph();

    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("Solved %0d small graphs from %0d weight transfers; %0d results checked.",
             graphs_solved, weights_sent, paths_checked);
    $display("Covered clamped counts, load restarts, threshold changes and a %0d-cycle receiver hold.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", expected_paths.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
